### rtl/core/acoptu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types, constants and functions of the pheromone table update core.
package acoptu_pkg;

	localparam int ADDR_W = 5;
	localparam int Q16_W = 17;
	localparam int CH_W = 24;
	localparam int AMT_W = 20;
	localparam int OBJ_W = 48;
	localparam int SLOT_Q_W = 9;

	localparam logic [16:0] ONE_Q16 = 17'd65536;
	localparam logic [23:0] CHOICE_MAX = 24'hFFFFFF;

	localparam logic [2:0] FN_RESET = 3'd0;
	localparam logic [2:0] FN_LOAD = 3'd1;
	localparam logic [2:0] FN_LOCAL = 3'd2;
	localparam logic [2:0] FN_EVAP = 3'd3;
	localparam logic [2:0] FN_DEPOSIT = 3'd4;
	localparam logic [2:0] FN_READ = 3'd5;

	localparam logic [2:0] REG_BLOCKS = 3'd0;
	localparam logic [2:0] REG_PERIODS = 3'd1;
	localparam logic [2:0] REG_DESTS = 3'd2;
	localparam logic [2:0] REG_RATE = 3'd3;
	localparam logic [2:0] REG_FLOOR = 3'd4;
	localparam logic [2:0] REG_CEILING = 3'd5;

	typedef struct packed {
		logic [16:0] blocks;
		logic [8:0] periods;
		logic [6:0] dests;
		logic [16:0] rate;
		logic [16:0] floor_lv;
		logic [16:0] ceil_lv;
	} cfg_t;

	typedef enum logic [2:0] {
		WM_CLEAR = 3'b001,
		WM_FILL = 3'b010,
		WM_EVAP = 3'b100
	} walk_mode_t;

	typedef struct packed {
		logic ld_item;
		logic norm;
		logic walk_clr;
		logic walk_inc;
		walk_mode_t walk_mode;
		logic addr_walk;
		logic mem_rd;
		logic calc_a;
		logic calc_b;
		logic calc_c;
		logic wr_time;
		logic wr_dest;
		logic wr_fill;
		logic wr_heur;
		logic div_start;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic norm_done;
		logic walk_last;
		logic div_done;
		logic [2:0] func;
		logic not_mined;
		logic no_dest;
	} sts_t;

	typedef logic [255:0][16:0] recip_tbl_t;

	// Rounded Q1.16 reciprocals of 1..256, entry n-1 holds round(65536 / n).
	function automatic recip_tbl_t build_recip();
		recip_tbl_t t;
		logic [17:0] num;
		logic [17:0] rem;
		logic [16:0] quo;
		t = '0;
		for (int n = 1; n <= 256; n++) begin
			num = 18'(65536 + (n >> 1));
			rem = '0;
			quo = '0;
			for (int b = 16; b >= 0; b--) begin
				rem = {rem[16:0], num[b]};
				if (rem >= 18'(n)) begin
					rem = rem - 18'(n);
					quo[b] = 1'b1;
				end
			end
			t[n - 1] = quo;
		end
		return t;
	endfunction

	localparam recip_tbl_t RECIP_TBL = build_recip();

	function automatic logic [16:0] recip_q16(input logic [8:0] n);
		return (n == 9'd0) ? 17'd0 : RECIP_TBL[8'(n - 9'd1)];
	endfunction

	function automatic logic [23:0] choice_sat(input logic [40:0] prod);
		return prod[40] ? CHOICE_MAX : prod[39:16];
	endfunction

endpackage
`default_nettype wire

### rtl/core/acoptu_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// Configuration register file behind the APB-style port.
module acoptu_regs #(
	parameter int MAX_BLOCKS = 1024,
	parameter int MAX_PERIODS = 16,
	parameter int MAX_DESTS = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [acoptu_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output acoptu_pkg::cfg_t cfg
);
	import acoptu_pkg::*;

	localparam int BLK_RST = (MAX_BLOCKS < 1024) ? MAX_BLOCKS : 1024;
	localparam int PER_RST = (MAX_PERIODS < 16) ? MAX_PERIODS : 16;
	localparam int DST_RST = (MAX_DESTS < 4) ? MAX_DESTS : 4;

	cfg_t cfg_q;
	logic wr;
	logic [2:0] idx;
	logic [16:0] q16_val;

	assign wr = psel & penable & pwrite;
	assign idx = paddr[4:2];
	assign q16_val = (pwdata > 32'd65536) ? ONE_Q16 : pwdata[16:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.blocks <= 17'(BLK_RST);
			cfg_q.periods <= 9'(PER_RST);
			cfg_q.dests <= 7'(DST_RST);
			cfg_q.rate <= 17'd6554;
			cfg_q.floor_lv <= 17'd66;
			cfg_q.ceil_lv <= 17'd65470;
		end else if (wr) begin
			case (idx)
				REG_BLOCKS: begin
					if (pwdata == 32'd0) cfg_q.blocks <= 17'd1;
					else if (pwdata > 32'(MAX_BLOCKS)) cfg_q.blocks <= 17'(MAX_BLOCKS);
					else cfg_q.blocks <= pwdata[16:0];
				end
				REG_PERIODS: begin
					if (pwdata == 32'd0) cfg_q.periods <= 9'd1;
					else if (pwdata > 32'(MAX_PERIODS)) cfg_q.periods <= 9'(MAX_PERIODS);
					else cfg_q.periods <= pwdata[8:0];
				end
				REG_DESTS: begin
					if (pwdata == 32'd0) cfg_q.dests <= 7'd1;
					else if (pwdata > 32'(MAX_DESTS)) cfg_q.dests <= 7'(MAX_DESTS);
					else cfg_q.dests <= pwdata[6:0];
				end
				REG_RATE: cfg_q.rate <= q16_val;
				REG_FLOOR: cfg_q.floor_lv <= q16_val;
				REG_CEILING: cfg_q.ceil_lv <= q16_val;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_BLOCKS: prdata = 32'(cfg_q.blocks);
			REG_PERIODS: prdata = 32'(cfg_q.periods);
			REG_DESTS: prdata = 32'(cfg_q.dests);
			REG_RATE: prdata = 32'(cfg_q.rate);
			REG_FLOOR: prdata = 32'(cfg_q.floor_lv);
			REG_CEILING: prdata = 32'(cfg_q.ceil_lv);
			default: prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

### rtl/core/acoptu_div10.sv
`timescale 1ns / 1ps
`default_nettype none
// Deposit amount unit: decimal scaling of the objective magnitude and a bit-serial quotient.
module acoptu_div10 (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [47:0] mag,
	output logic done,
	output logic [19:0] amount
);
	typedef enum logic [2:0] {
		DV_IDLE = 3'b001,
		DV_SCALE = 3'b010,
		DV_DIV = 3'b100
	} dv_state_t;

	dv_state_t state_q;
	logic [47:0] mag_q;
	logic [49:0] pow_q;
	logic [49:0] rem_q;
	logic [19:0] low_q;
	logic [19:0] quo_q;
	logic [4:0] cnt_q;
	logic done_q;
	logic [53:0] pow10;
	logic grow;
	logic [50:0] rem_sh;
	logic take;

	assign pow10 = 54'({pow_q, 3'b000}) + 54'({pow_q, 1'b0});
	assign grow = 54'(mag_q) > pow10;
	assign rem_sh = {rem_q, low_q[19]};
	assign take = rem_sh >= 51'(pow_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				DV_IDLE: begin
					if (start) state_q <= DV_SCALE;
				end
				DV_SCALE: begin
					cnt_q <= '0;
					if (!grow) state_q <= DV_DIV;
				end
				DV_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd19) begin
						done_q <= 1'b1;
						state_q <= DV_IDLE;
					end
				end
				default: state_q <= DV_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == DV_IDLE && start) begin
			mag_q <= mag;
			pow_q <= 50'd1;
		end else if (state_q == DV_SCALE) begin
			if (grow) begin
				pow_q <= pow10[49:0];
			end else begin
				rem_q <= 50'(mag_q[47:4]);
				low_q <= {mag_q[3:0], 16'd0};
			end
		end else if (state_q == DV_DIV) begin
			rem_q <= take ? 50'(rem_sh - 51'(pow_q)) : rem_sh[49:0];
			low_q <= {low_q[18:0], 1'b0};
			quo_q <= {quo_q[18:0], take};
		end
	end

	assign done = done_q;
	assign amount = quo_q;

endmodule
`default_nettype wire

### rtl/core/acoptu_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// Datapath: item registers, table memories, walk counters, update arithmetic, result register.
module acoptu_dp #(
	parameter int MAX_BLOCKS = 1024,
	parameter int MAX_PERIODS = 16,
	parameter int MAX_DESTS = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  acoptu_pkg::cfg_t cfg,
	input  acoptu_pkg::cmd_t cmd,
	output acoptu_pkg::sts_t sts,
	input  logic [2:0] func,
	input  logic [9:0] block,
	input  logic [3:0] period,
	input  logic not_mined,
	input  logic [1:0] destination,
	input  logic no_destination,
	input  logic [23:0] heuristic_value,
	input  logic signed [47:0] objective,
	output logic [16:0] time_pheromone,
	output logic [23:0] time_choice,
	output logic [16:0] dest_pheromone,
	output logic [23:0] dest_choice
);
	import acoptu_pkg::*;

	localparam int SLOTS = MAX_PERIODS + 1;
	localparam int SW = $clog2(SLOTS);
	localparam int BW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int DW = (MAX_DESTS > 1) ? $clog2(MAX_DESTS) : 1;
	localparam int JMAX = (MAX_PERIODS > MAX_DESTS - 1) ? MAX_PERIODS : MAX_DESTS - 1;
	localparam int JW = $clog2(JMAX + 1);
	localparam int BQW = (BW > 10) ? BW : 10;
	localparam int DQW = (DW > 2) ? DW : 2;
	localparam int TDEPTH = MAX_BLOCKS * (2 ** SW);
	localparam int DDEPTH = MAX_BLOCKS * (2 ** DW);
	localparam int PER_RST = (MAX_PERIODS < 16) ? MAX_PERIODS : 16;
	localparam int DST_RST = (MAX_DESTS < 4) ? MAX_DESTS : 4;
	localparam logic [16:0] RT_RST = recip_q16(9'(PER_RST));
	localparam logic [16:0] RD_RST = recip_q16(9'(DST_RST));

	logic [2:0] func_q;
	logic [BQW-1:0] blk_q;
	logic [SLOT_Q_W-1:0] slot_q;
	logic [DQW-1:0] dst_q;
	logic nm_q;
	logic nodest_q;
	logic [23:0] hval_q;
	logic [47:0] obj_q;

	logic [BW-1:0] wb_q;
	logic [JW-1:0] wj_q;
	logic [31:0] jmax;
	logic row_end;
	logic blk_last;

	logic [BW+SW-1:0] ta;
	logic [BW+DW-1:0] da;
	logic [40:0] time_mem [TDEPTH];
	logic [40:0] dest_mem [DDEPTH];
	logic [23:0] heur_mem [TDEPTH];
	logic [40:0] t_rd_q;
	logic [40:0] d_rd_q;
	logic [23:0] h_rd_q;

	logic time_ok;
	logic dest_ok;
	logic [16:0] fill_t;
	logic [16:0] fill_d;
	logic t_we;
	logic d_we;
	logic [40:0] t_wd;
	logic [40:0] d_wd;

	logic [16:0] keep;
	logic [33:0] prod_t_q;
	logic [33:0] prod_d_q;
	logic [17:0] dec_t;
	logic [17:0] dec_d;
	logic [18:0] loc_t;
	logic [18:0] loc_d;
	logic [20:0] dep_t;
	logic [20:0] dep_d;
	logic [16:0] dep_d1;
	logic [16:0] tpn_c;
	logic [16:0] dpn_c;
	logic [16:0] tpn_q;
	logic [16:0] dpn_q;
	logic [40:0] cht_q;
	logic [40:0] chd_q;

	logic [19:0] amt_q;
	logic [47:0] mag;
	logic div_done;
	logic [19:0] div_amt;

	logic [16:0] res_tp_q;
	logic [23:0] res_tc_q;
	logic [16:0] res_dp_q;
	logic [23:0] res_dc_q;

	always_ff @(posedge clk) begin
		if (cmd.ld_item) begin
			func_q <= func;
			blk_q <= BQW'(block);
			slot_q <= not_mined ? cfg.periods : SLOT_Q_W'(period);
			dst_q <= DQW'(destination);
			nm_q <= not_mined;
			nodest_q <= no_destination;
			hval_q <= heuristic_value;
			obj_q <= objective;
		end else if (cmd.norm) begin
			if (32'(blk_q) >= MAX_BLOCKS) blk_q <= blk_q - BQW'(MAX_BLOCKS);
			if (32'(slot_q) >= SLOTS) slot_q <= slot_q - SLOT_Q_W'(SLOTS);
			if (32'(dst_q) >= MAX_DESTS) dst_q <= dst_q - DQW'(MAX_DESTS);
		end
	end

	assign sts.norm_done = (32'(blk_q) < MAX_BLOCKS) && (32'(slot_q) < SLOTS)
		&& (32'(dst_q) < MAX_DESTS);
	assign sts.func = func_q;
	assign sts.not_mined = nm_q;
	assign sts.no_dest = nodest_q;

	always_comb begin
		unique case (cmd.walk_mode)
			WM_CLEAR: jmax = 32'(JMAX);
			WM_FILL: jmax = (32'(cfg.periods) > 32'(cfg.dests) - 32'd1) ?
				32'(cfg.periods) : 32'(cfg.dests) - 32'd1;
			WM_EVAP: jmax = 32'(cfg.periods);
			default: jmax = 32'(JMAX);
		endcase
	end

	assign row_end = 32'(wj_q) == jmax;
	assign blk_last = (cmd.walk_mode == WM_CLEAR) ? (32'(wb_q) == MAX_BLOCKS - 1) :
		(32'(wb_q) == 32'(cfg.blocks) - 32'd1);
	assign sts.walk_last = row_end & blk_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_q <= '0;
			wj_q <= '0;
		end else if (cmd.walk_clr) begin
			wb_q <= '0;
			wj_q <= '0;
		end else if (cmd.walk_inc) begin
			if (row_end) begin
				wj_q <= '0;
				wb_q <= wb_q + BW'(1);
			end else begin
				wj_q <= wj_q + JW'(1);
			end
		end
	end

	assign ta = cmd.addr_walk ? {wb_q, wj_q[SW-1:0]} : {blk_q[BW-1:0], slot_q[SW-1:0]};
	assign da = cmd.addr_walk ? {wb_q, wj_q[DW-1:0]} : {blk_q[BW-1:0], dst_q[DW-1:0]};

	assign time_ok = (cmd.walk_mode == WM_CLEAR) ? (32'(wj_q) <= MAX_PERIODS) :
		(32'(wj_q) <= 32'(cfg.periods));
	assign dest_ok = (cmd.walk_mode == WM_CLEAR) ? (32'(wj_q) < MAX_DESTS) :
		(32'(wj_q) < 32'(cfg.dests));
	assign fill_t = (cmd.walk_mode == WM_CLEAR) ? RT_RST : recip_q16(cfg.periods);
	assign fill_d = (cmd.walk_mode == WM_CLEAR) ? RD_RST : recip_q16({2'b00, cfg.dests});

	assign t_we = cmd.wr_time & (!cmd.wr_fill | time_ok);
	assign d_we = cmd.wr_dest & (!cmd.wr_fill | dest_ok);
	assign t_wd = cmd.wr_fill ? {fill_t, 7'd0, fill_t} : {tpn_q, choice_sat(cht_q)};
	assign d_wd = cmd.wr_fill ? {fill_d, 7'd0, fill_d} :
		{dpn_q, (func_q == FN_DEPOSIT) ? {7'd0, dpn_q} : choice_sat(chd_q)};

	always_ff @(posedge clk) begin
		if (t_we) time_mem[ta] <= t_wd;
		if (cmd.mem_rd) t_rd_q <= time_mem[ta];
	end

	always_ff @(posedge clk) begin
		if (d_we) dest_mem[da] <= d_wd;
		if (cmd.mem_rd) d_rd_q <= dest_mem[da];
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_heur) heur_mem[ta] <= hval_q;
		if (cmd.mem_rd) h_rd_q <= heur_mem[ta];
	end

	assign keep = ONE_Q16 - cfg.rate;

	always_ff @(posedge clk) begin
		if (cmd.calc_a) begin
			prod_t_q <= 34'(keep) * 34'(t_rd_q[40:24]);
			prod_d_q <= 34'(keep) * 34'(d_rd_q[40:24]);
		end
	end

	assign dec_t = prod_t_q[33:16];
	assign dec_d = prod_d_q[33:16];
	assign loc_t = 19'(dec_t) + 19'(cfg.floor_lv);
	assign loc_d = 19'(dec_d) + 19'(cfg.floor_lv);
	assign dep_t = 21'(t_rd_q[40:24]) + 21'(amt_q);
	assign dep_d = 21'(dec_d) + 21'(amt_q);
	assign dep_d1 = (dep_d > 21'(cfg.ceil_lv)) ? cfg.ceil_lv : dep_d[16:0];

	always_comb begin
		tpn_c = t_rd_q[40:24];
		dpn_c = d_rd_q[40:24];
		case (func_q)
			FN_LOCAL: begin
				tpn_c = (loc_t > 19'(ONE_Q16)) ? ONE_Q16 : loc_t[16:0];
				dpn_c = (loc_d > 19'(ONE_Q16)) ? ONE_Q16 : loc_d[16:0];
			end
			FN_EVAP: begin
				tpn_c = (dec_t < 18'(cfg.floor_lv)) ? cfg.floor_lv : dec_t[16:0];
			end
			FN_DEPOSIT: begin
				tpn_c = (dep_t > 21'(cfg.ceil_lv)) ? cfg.ceil_lv : dep_t[16:0];
				dpn_c = (dep_d1 < cfg.floor_lv) ? cfg.floor_lv : dep_d1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.calc_b) begin
			tpn_q <= tpn_c;
			dpn_q <= dpn_c;
		end
		if (cmd.calc_c) begin
			cht_q <= 41'(tpn_q) * 41'(h_rd_q);
			chd_q <= 41'(dpn_q) * 41'(h_rd_q);
		end
	end

	assign mag = obj_q[47] ? (48'd0 - obj_q) : obj_q;

	acoptu_div10 u_div10 (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.div_start),
		.mag(mag),
		.done(div_done),
		.amount(div_amt)
	);

	assign sts.div_done = div_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) amt_q <= '0;
		else if (div_done) amt_q <= div_amt;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_tp_q <= t_rd_q[40:24];
			res_tc_q <= t_rd_q[23:0];
			res_dp_q <= d_rd_q[40:24];
			res_dc_q <= d_rd_q[23:0];
		end
	end

	assign time_pheromone = res_tp_q;
	assign time_choice = res_tc_q;
	assign dest_pheromone = res_dp_q;
	assign dest_choice = res_dc_q;

endmodule
`default_nettype wire

### rtl/core/acoptu_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// Controller state machine sequencing the datapath per transaction.
module acoptu_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_ready,
	output logic result_valid,
	input  logic result_ready,
	input  acoptu_pkg::sts_t sts,
	output acoptu_pkg::cmd_t cmd
);
	import acoptu_pkg::*;

	typedef enum logic [12:0] {
		ST_CLEAR = 13'b0000000000001,
		ST_IDLE = 13'b0000000000010,
		ST_NORM = 13'b0000000000100,
		ST_FILL = 13'b0000000001000,
		ST_HEUR = 13'b0000000010000,
		ST_RD = 13'b0000000100000,
		ST_CA = 13'b0000001000000,
		ST_CB = 13'b0000010000000,
		ST_CC = 13'b0000100000000,
		ST_WR = 13'b0001000000000,
		ST_DIV = 13'b0010000000000,
		ST_ORD = 13'b0100000000000,
		ST_OUT = 13'b1000000000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic out_valid_q;
	logic evap;

	assign evap = sts.func == FN_EVAP;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.walk_mode = WM_FILL;
		item_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.walk_mode = WM_CLEAR;
				cmd.addr_walk = 1'b1;
				cmd.wr_time = 1'b1;
				cmd.wr_dest = 1'b1;
				cmd.wr_fill = 1'b1;
				if (sts.walk_last) begin
					cmd.walk_clr = 1'b1;
					state_d = ST_IDLE;
				end else begin
					cmd.walk_inc = 1'b1;
				end
			end
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.ld_item = 1'b1;
					cmd.walk_clr = 1'b1;
					state_d = ST_NORM;
				end
			end
			ST_NORM: begin
				if (!sts.norm_done) begin
					cmd.norm = 1'b1;
				end else begin
					case (sts.func)
						FN_RESET: state_d = ST_FILL;
						FN_LOAD: state_d = ST_HEUR;
						FN_LOCAL, FN_EVAP, FN_DEPOSIT: state_d = ST_RD;
						default: state_d = ST_ORD;
					endcase
				end
			end
			ST_FILL: begin
				cmd.addr_walk = 1'b1;
				cmd.wr_time = 1'b1;
				cmd.wr_dest = 1'b1;
				cmd.wr_fill = 1'b1;
				if (sts.walk_last) state_d = ST_ORD;
				else cmd.walk_inc = 1'b1;
			end
			ST_HEUR: begin
				cmd.wr_heur = 1'b1;
				state_d = ST_ORD;
			end
			ST_RD: begin
				cmd.addr_walk = evap;
				cmd.mem_rd = 1'b1;
				state_d = ST_CA;
			end
			ST_CA: begin
				cmd.calc_a = 1'b1;
				state_d = ST_CB;
			end
			ST_CB: begin
				cmd.calc_b = 1'b1;
				state_d = ST_CC;
			end
			ST_CC: begin
				cmd.calc_c = 1'b1;
				state_d = ST_WR;
			end
			ST_WR: begin
				cmd.walk_mode = WM_EVAP;
				cmd.addr_walk = evap;
				cmd.wr_time = 1'b1;
				cmd.wr_dest = ((sts.func == FN_LOCAL) && !sts.no_dest)
					|| ((sts.func == FN_DEPOSIT) && !sts.not_mined);
				if (!evap) begin
					state_d = ST_ORD;
				end else if (sts.walk_last) begin
					cmd.div_start = 1'b1;
					state_d = ST_DIV;
				end else begin
					cmd.walk_inc = 1'b1;
					state_d = ST_RD;
				end
			end
			ST_DIV: begin
				if (sts.div_done) state_d = ST_ORD;
			end
			ST_ORD: begin
				cmd.mem_rd = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || result_ready) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (result_ready) out_valid_q <= 1'b0;
		end
	end

	assign result_valid = out_valid_q;

endmodule
`default_nettype wire

### rtl/core/aco_pheromone_table_update_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Top level of the ant-colony pheromone table update core.
//
// Items enter on the item channel (item_valid/item_ready) and each yields one
// result on the result channel (result_valid/result_ready): the time and
// destination entries at the addressed block after the operation. The user
// must see that registers are written through the APB-style port only while
// no transaction is in flight; the block does not enforce this. One item is
// processed at a time: its indices are reduced modulo the table sizes,
// heuristic load writes the heuristic table, local update and deposit run
// the read, CA/CB/CC arithmetic and write states, and each item ends with a
// table read into the output register. Evaporation runs every time entry of
// the blocks in use through the shared read/multiply/write sequence, then
// scales and divides the objective. After reset a clearing pass loads the
// tables with their initial values; item_ready stays low meanwhile. A
// finished result waits in the output register while the receiver stalls;
// the next item is accepted before it is taken.
module aco_pheromone_table_update_core #(
	parameter int MAX_BLOCKS = 1024,
	parameter int MAX_PERIODS = 16,
	parameter int MAX_DESTS = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_ready,
	input  logic [2:0] func,
	input  logic [9:0] block,
	input  logic [3:0] period,
	input  logic not_mined,
	input  logic [1:0] destination,
	input  logic no_destination,
	input  logic [23:0] heuristic_value,
	input  logic signed [47:0] objective,
	output logic result_valid,
	input  logic result_ready,
	output logic [16:0] time_pheromone,
	output logic [23:0] time_choice,
	output logic [16:0] dest_pheromone,
	output logic [23:0] dest_choice,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [acoptu_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import acoptu_pkg::*;

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	assign pready = 1'b1;

	acoptu_regs #(
		.MAX_BLOCKS(MAX_BLOCKS),
		.MAX_PERIODS(MAX_PERIODS),
		.MAX_DESTS(MAX_DESTS)
	) u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.cfg(cfg)
	);

	acoptu_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.sts(sts),
		.cmd(cmd)
	);

	acoptu_dp #(
		.MAX_BLOCKS(MAX_BLOCKS),
		.MAX_PERIODS(MAX_PERIODS),
		.MAX_DESTS(MAX_DESTS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.cmd(cmd),
		.sts(sts),
		.func(func),
		.block(block),
		.period(period),
		.not_mined(not_mined),
		.destination(destination),
		.no_destination(no_destination),
		.heuristic_value(heuristic_value),
		.objective(objective),
		.time_pheromone(time_pheromone),
		.time_choice(time_choice),
		.dest_pheromone(dest_pheromone),
		.dest_choice(dest_choice)
	);

endmodule
`default_nettype wire

### rtl/core/acoptu_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// Port-level checker of the pheromone table update core and its bind.
module acoptu_checker (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic item_ready,
	input logic result_valid,
	input logic result_ready,
	input logic [16:0] time_pheromone,
	input logic [23:0] time_choice,
	input logic [16:0] dest_pheromone,
	input logic [23:0] dest_choice
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped while stalled");

	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(time_pheromone) && $stable(time_choice)
			&& $stable(dest_pheromone) && $stable(dest_choice))
		else $error("result payload changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item accepted while previous transaction in flight");

	a_pheromone_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (time_pheromone <= 17'd65536) && (dest_pheromone <= 17'd65536))
		else $error("pheromone above one");

endmodule

bind aco_pheromone_table_update_core acoptu_checker u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.item_valid(item_valid),
	.item_ready(item_ready),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.time_pheromone(time_pheromone),
	.time_choice(time_choice),
	.dest_pheromone(dest_pheromone),
	.dest_choice(dest_choice)
);
`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the pheromone table update core, with its own table predictor.
module tb_top;
	import acoptu_pkg::*;

	localparam int SLOTS = 17;
	localparam int NBLK = 1024;
	localparam int NDST = 4;
	localparam logic [2:0] FN_SPARE6 = 3'd6;
	localparam logic [2:0] FN_SPARE7 = 3'd7;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int RANDOM_ITEMS = 40;
	localparam int NPHASES = 5;

	typedef struct {
		logic [2:0] fn;
		logic [9:0] blk;
		logic [3:0] per;
		logic nm;
		logic [1:0] dst;
		logic nd;
		logic [23:0] hv;
		logic [47:0] obj;
	} item_t;

	typedef struct {
		logic [16:0] tp;
		logic [23:0] tc;
		logic [16:0] dp;
		logic [23:0] dc;
	} entry_t;

	typedef struct {
		item_t it;
		bit typed;
		entry_t want;
	} row_t;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_ready;
	logic [2:0] func;
	logic [9:0] block;
	logic [3:0] period;
	logic not_mined;
	logic [1:0] destination;
	logic no_destination;
	logic [23:0] heuristic_value;
	logic signed [47:0] objective;
	logic result_valid;
	logic result_ready;
	logic [16:0] time_pheromone;
	logic [23:0] time_choice;
	logic [16:0] dest_pheromone;
	logic [23:0] dest_choice;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	int unsigned time_pher[0:NBLK*SLOTS-1];
	int unsigned time_chc[0:NBLK*SLOTS-1];
	int unsigned heur[0:NBLK*SLOTS-1];
	bit heur_loaded[0:NBLK*SLOTS-1];
	int unsigned dest_pher[0:NBLK*NDST-1];
	int unsigned dest_chc[0:NBLK*NDST-1];
	int unsigned amount;
	int unsigned blocks_n, periods_n, dests_n, rate_n, floor_n, ceil_n;

	entry_t pending_q[$];
	row_t dir_rows[$];
	int fails;
	int cycles;
	int burst_left;
	int stall_left;
	bit rx_free;

	aco_pheromone_table_update_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.func(func),
		.block(block),
		.period(period),
		.not_mined(not_mined),
		.destination(destination),
		.no_destination(no_destination),
		.heuristic_value(heuristic_value),
		.objective(objective),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.time_pheromone(time_pheromone),
		.time_choice(time_choice),
		.dest_pheromone(dest_pheromone),
		.dest_choice(dest_choice),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned recip_of(int unsigned n);
		return (65536 + n / 2) / n;
	endfunction

	function automatic int unsigned decayed(int unsigned x);
		return int'((longint'(65536 - rate_n) * x) >> 16);
	endfunction

	function automatic int unsigned choice_of(int unsigned p, int unsigned h);
		longint unsigned c;
		c = (longint'(p) * h) >> 16;
		return c > 64'hFFFFFF ? 32'hFFFFFF : int'(c);
	endfunction

	function automatic int unsigned sat_one(longint unsigned v);
		return v > 65536 ? 65536 : int'(v);
	endfunction

	function automatic int unsigned slot_of(item_t it);
		return (it.nm ? periods_n : int'(it.per)) % SLOTS;
	endfunction

	function automatic void fill_block(int unsigned b);
		int unsigned rt, rd;
		rt = recip_of(periods_n);
		rd = recip_of(dests_n);
		for (int j = 0; j <= periods_n; j++) begin
			time_pher[b*SLOTS+j] = rt;
			time_chc[b*SLOTS+j] = rt;
		end
		for (int j = 0; j < dests_n; j++) begin
			dest_pher[b*NDST+j] = rd;
			dest_chc[b*NDST+j] = rd;
		end
	endfunction

	function automatic entry_t predict_entry(item_t it);
		int unsigned ti, di, h, p, k;
		longint unsigned q, mag, d;
		logic [47:0] m48;
		entry_t r;
		ti = int'(it.blk) * SLOTS + slot_of(it);
		di = int'(it.blk) * NDST + int'(it.dst);
		case (it.fn)
			FN_RESET: begin
				for (int b = 0; b < blocks_n; b++) fill_block(b);
			end
			FN_LOAD: begin
				heur[ti] = it.hv;
				heur_loaded[ti] = 1'b1;
			end
			FN_LOCAL: begin
				h = heur[ti];
				time_pher[ti] = sat_one(longint'(decayed(time_pher[ti])) + floor_n);
				time_chc[ti] = choice_of(time_pher[ti], h);
				if (!it.nd) begin
					dest_pher[di] = sat_one(longint'(decayed(dest_pher[di])) + floor_n);
					dest_chc[di] = choice_of(dest_pher[di], h);
				end
			end
			FN_EVAP: begin
				for (int b = 0; b < blocks_n; b++) begin
					for (int j = 0; j <= periods_n; j++) begin
						k = b * SLOTS + j;
						p = decayed(time_pher[k]);
						if (p < floor_n) p = floor_n;
						time_pher[k] = p;
						time_chc[k] = choice_of(p, heur[k]);
					end
				end
				m48 = it.obj[47] ? (~it.obj + 48'd1) : it.obj;
				mag = m48;
				d = 1;
				while (mag > 10 * d) d = d * 10;
				amount = int'(((mag << 16) / d) & 64'hFFFFF);
			end
			FN_DEPOSIT: begin
				q = longint'(time_pher[ti]) + amount;
				if (q > ceil_n) q = ceil_n;
				time_pher[ti] = int'(q);
				time_chc[ti] = choice_of(int'(q), heur[ti]);
				if (!it.nm) begin
					q = longint'(decayed(dest_pher[di])) + amount;
					if (q > ceil_n) q = ceil_n;
					if (q < floor_n) q = floor_n;
					dest_pher[di] = int'(q);
					dest_chc[di] = int'(q);
				end
			end
			default: begin
			end
		endcase
		r.tp = time_pher[ti][16:0];
		r.tc = time_chc[ti][23:0];
		r.dp = dest_pher[di][16:0];
		r.dc = dest_chc[di][23:0];
		return r;
	endfunction

	function automatic item_t mk_item(logic [2:0] fn, logic [9:0] blk, logic [3:0] per,
		logic nm, logic [1:0] dst, logic nd, logic [23:0] hv, logic [47:0] obj);
		item_t it;
		it.fn = fn;
		it.blk = blk;
		it.per = per;
		it.nm = nm;
		it.dst = dst;
		it.nd = nd;
		it.hv = hv;
		it.obj = obj;
		return it;
	endfunction

	function automatic void add_row(item_t it, bit typed, int unsigned tp, int unsigned tc,
		int unsigned dp, int unsigned dc);
		row_t r;
		r.it = it;
		r.typed = typed;
		r.want.tp = tp[16:0];
		r.want.tc = tc[23:0];
		r.want.dp = dp[16:0];
		r.want.dc = dc[23:0];
		dir_rows.push_back(r);
	endfunction

	task automatic send_item(item_t it, bit typed, entry_t want);
		entry_t e;
		@(negedge clk);
		func = it.fn;
		block = it.blk;
		period = it.per;
		not_mined = it.nm;
		destination = it.dst;
		no_destination = it.nd;
		heuristic_value = it.hv;
		objective = it.obj;
		item_valid = 1'b1;
		do @(posedge clk); while (!item_ready);
		e = predict_entry(it);
		pending_q.push_back(typed ? want : e);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			@(negedge clk);
			item_valid = 1'b0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
			burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(10, 25) :
				$urandom_range(0, 5);
		end
	endtask

	task automatic issue(item_t it);
		entry_t none;
		none = '{default: '0};
		send_item(it, 1'b0, none);
	endtask

	task automatic load_slot(int unsigned b, int unsigned s);
		if (!heur_loaded[b*SLOTS+s])
			issue(mk_item(FN_LOAD, b[9:0], s[3:0], s > 15, 2'($urandom), 1'($urandom),
				24'($urandom), 48'd0));
	endtask

	task automatic prepare_heur(item_t it);
		if (it.fn == FN_LOCAL || it.fn == FN_DEPOSIT) begin
			if (!heur_loaded[int'(it.blk)*SLOTS + slot_of(it)])
				issue(mk_item(FN_LOAD, it.blk, it.per, it.nm, it.dst, it.nd,
					24'($urandom), 48'd0));
		end else if (it.fn == FN_EVAP) begin
			for (int b = 0; b < blocks_n; b++)
				for (int j = 0; j <= periods_n; j++) load_slot(b, j);
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		item_valid = 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic int unsigned clamp_cnt(int unsigned v, int unsigned hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	task automatic write_reg(logic [2:0] idx, int unsigned val);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = ADDR_W'({idx, 2'b00});
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		case (idx)
			REG_BLOCKS: blocks_n = clamp_cnt(val, NBLK);
			REG_PERIODS: periods_n = clamp_cnt(val, 16);
			REG_DESTS: dests_n = clamp_cnt(val, NDST);
			REG_RATE: rate_n = val > 65536 ? 65536 : val;
			REG_FLOOR: floor_n = val > 65536 ? 65536 : val;
			REG_CEILING: ceil_n = val > 65536 ? 65536 : val;
			default: begin
			end
		endcase
	endtask

	task automatic write_all(int unsigned c[6]);
		write_reg(REG_BLOCKS, c[0]);
		write_reg(REG_PERIODS, c[1]);
		write_reg(REG_DESTS, c[2]);
		write_reg(REG_RATE, c[3]);
		write_reg(REG_FLOOR, c[4]);
		write_reg(REG_CEILING, c[5]);
	endtask

	function automatic item_t random_item();
		item_t it;
		int unsigned r, lim;
		logic [63:0] raw;
		r = $urandom_range(0, 99);
		if (r < 18) it.fn = FN_LOAD;
		else if (r < 40) it.fn = FN_LOCAL;
		else if (r < 62) it.fn = FN_DEPOSIT;
		else if (r < 74) it.fn = blocks_n <= 8 ? FN_EVAP : FN_READ;
		else if (r < 90) it.fn = FN_READ;
		else if (r < 94) it.fn = FN_RESET;
		else it.fn = $urandom_range(0, 1) ? FN_SPARE6 : FN_SPARE7;
		lim = blocks_n < 8 ? blocks_n : 8;
		it.blk = $urandom_range(0, 4) == 0 ? 10'($urandom) : 10'($urandom_range(0, lim - 1));
		it.per = 4'($urandom);
		it.nm = $urandom_range(0, 3) == 0;
		it.dst = 2'($urandom);
		it.nd = 1'($urandom);
		it.hv = 24'($urandom);
		raw = {$urandom, $urandom};
		it.obj = 48'(raw >> $urandom_range(0, 63));
		if ($urandom_range(0, 1)) it.obj = -it.obj;
		return it;
	endfunction

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		func = FN_READ;
		block = '0;
		period = '0;
		not_mined = 1'b0;
		destination = '0;
		no_destination = 1'b0;
		heuristic_value = '0;
		objective = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		result_ready = 1'b0;
	end

	initial begin : stimulus
		int unsigned phase_cfg[NPHASES][6];
		int unsigned first_cfg[6];
		item_t it;
		entry_t none;
		none = '{default: '0};
		phase_cfg = '{
			'{3, 5, 2, 6554, 66, 65470},
			'{1, 1, 1, 65536, 65536, 0},
			'{2, 16, 4, 0, 0, 65536},
			'{2000, 0, 7, 70000, 100, 30000},
			'{2, 12, 3, 1000, 500, 60000}
		};
		first_cfg = '{1, 16, 4, 6554, 66, 65470};
		fails = 0;
		burst_left = 0;
		blocks_n = 1024;
		periods_n = 16;
		dests_n = 4;
		rate_n = 6554;
		floor_n = 66;
		ceil_n = 65470;
		amount = 0;
		for (int i = 0; i < NBLK * SLOTS; i++) begin
			time_pher[i] = recip_of(16);
			time_chc[i] = recip_of(16);
			heur[i] = 0;
			heur_loaded[i] = 1'b0;
		end
		for (int i = 0; i < NBLK * NDST; i++) begin
			dest_pher[i] = recip_of(4);
			dest_chc[i] = recip_of(4);
		end

		add_row(mk_item(FN_READ, 10'd0, 4'd0, 1'b0, 2'd0, 1'b0, 24'd0, 48'd0),
			1'b1, 4096, 4096, 16384, 16384);
		add_row(mk_item(FN_READ, 10'd1023, 4'd15, 1'b1, 2'd3, 1'b1, 24'hFFFFFF, 48'd0),
			1'b1, 4096, 4096, 16384, 16384);
		add_row(mk_item(FN_SPARE6, 10'd7, 4'd3, 1'b0, 2'd1, 1'b0, 24'd0, 48'd0),
			1'b1, 4096, 4096, 16384, 16384);
		add_row(mk_item(FN_SPARE7, 10'd9, 4'd8, 1'b0, 2'd2, 1'b0, 24'd0, 48'd0),
			1'b1, 4096, 4096, 16384, 16384);
		add_row(mk_item(FN_LOAD, 10'd0, 4'd0, 1'b0, 2'd0, 1'b0, 24'hFFFFFF, 48'd0),
			1'b1, 4096, 4096, 16384, 16384);
		add_row(mk_item(FN_LOAD, 10'd1023, 4'd15, 1'b0, 2'd3, 1'b0, 24'd0, 48'd0),
			1'b1, 4096, 4096, 16384, 16384);
		add_row(mk_item(FN_LOAD, 10'd5, 4'd0, 1'b1, 2'd0, 1'b0, 24'h010000, 48'd0),
			1'b1, 4096, 4096, 16384, 16384);
		add_row(mk_item(FN_LOCAL, 10'd0, 4'd0, 1'b0, 2'd0, 1'b0, 24'd0, 48'd0),
			1'b0, 0, 0, 0, 0);
		add_row(mk_item(FN_LOCAL, 10'd0, 4'd0, 1'b0, 2'd1, 1'b1, 24'd0, 48'd0),
			1'b0, 0, 0, 0, 0);
		add_row(mk_item(FN_LOCAL, 10'd1023, 4'd15, 1'b0, 2'd3, 1'b0, 24'd0, 48'd0),
			1'b0, 0, 0, 0, 0);
		add_row(mk_item(FN_LOCAL, 10'd5, 4'd0, 1'b1, 2'd2, 1'b0, 24'd0, 48'd0),
			1'b0, 0, 0, 0, 0);
		add_row(mk_item(FN_EVAP, 10'd0, 4'd0, 1'b0, 2'd0, 1'b0, 24'd0, 48'd0),
			1'b0, 0, 0, 0, 0);
		add_row(mk_item(FN_DEPOSIT, 10'd0, 4'd0, 1'b0, 2'd0, 1'b0, 24'd0, 48'd0),
			1'b0, 0, 0, 0, 0);
		add_row(mk_item(FN_EVAP, 10'd0, 4'd0, 1'b0, 2'd0, 1'b0, 24'd0, -48'sd1),
			1'b0, 0, 0, 0, 0);
		add_row(mk_item(FN_DEPOSIT, 10'd0, 4'd0, 1'b0, 2'd0, 1'b0, 24'd0, 48'd0),
			1'b0, 0, 0, 0, 0);
		add_row(mk_item(FN_EVAP, 10'd0, 4'd0, 1'b0, 2'd0, 1'b0, 24'd0, 48'h7FFFFFFFFFFF),
			1'b0, 0, 0, 0, 0);
		add_row(mk_item(FN_DEPOSIT, 10'd0, 4'd0, 1'b1, 2'd1, 1'b0, 24'd0, 48'd0),
			1'b0, 0, 0, 0, 0);
		add_row(mk_item(FN_EVAP, 10'd0, 4'd0, 1'b0, 2'd0, 1'b0, 24'd0, 48'h800000000000),
			1'b0, 0, 0, 0, 0);
		add_row(mk_item(FN_DEPOSIT, 10'd1023, 4'd15, 1'b0, 2'd3, 1'b0, 24'd0, 48'd0),
			1'b0, 0, 0, 0, 0);
		add_row(mk_item(FN_EVAP, 10'd0, 4'd0, 1'b0, 2'd0, 1'b0, 24'd0, 48'd10),
			1'b0, 0, 0, 0, 0);
		add_row(mk_item(FN_DEPOSIT, 10'd0, 4'd1, 1'b0, 2'd2, 1'b0, 24'd0, 48'd0),
			1'b0, 0, 0, 0, 0);
		add_row(mk_item(FN_EVAP, 10'd0, 4'd0, 1'b0, 2'd0, 1'b0, 24'd0, 48'd11),
			1'b0, 0, 0, 0, 0);
		add_row(mk_item(FN_DEPOSIT, 10'd0, 4'd2, 1'b0, 2'd0, 1'b0, 24'd0, 48'd0),
			1'b0, 0, 0, 0, 0);
		add_row(mk_item(FN_RESET, 10'd0, 4'd0, 1'b0, 2'd0, 1'b0, 24'd0, 48'd0),
			1'b0, 0, 0, 0, 0);
		add_row(mk_item(FN_READ, 10'd0, 4'd3, 1'b0, 2'd3, 1'b0, 24'd0, 48'd0),
			1'b1, 4096, 4096, 16384, 16384);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(posedge clk);
		write_all(first_cfg);

		foreach (dir_rows[i]) begin
			prepare_heur(dir_rows[i].it);
			send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
		end

		for (int ph = 0; ph < NPHASES; ph++) begin
			wait_drained();
			write_all(phase_cfg[ph]);
			issue(mk_item(FN_RESET, 10'd0, 4'd0, 1'b0, 2'd0, 1'b0, 24'd0, 48'd0));
			for (int n = 0; n < RANDOM_ITEMS / NPHASES; n++) begin
				it = random_item();
				prepare_heur(it);
				issue(it);
			end
		end

		wait_drained();
		repeat (100) @(posedge clk);
		if (fails == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
			if (!rx_free && $urandom_range(0, 5) == 0)
				stall_left <= $urandom_range(1, 8);
			if ($urandom_range(0, 63) == 0)
				rx_free <= !rx_free;
		end
	end

	initial begin
		stall_left = 0;
		rx_free = 1'b0;
	end

	always @(posedge clk) begin : result_check
		entry_t e;
		if (arst_n && result_valid && result_ready) begin
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result tp=%0d tc=%0d dp=%0d dc=%0d", $time,
					time_pheromone, time_choice, dest_pheromone, dest_choice);
				fails++;
			end else begin
				e = pending_q.pop_front();
				if (time_pheromone !== e.tp) begin
					$display("%0t: time_pheromone expected %0d actual %0d", $time, e.tp,
						time_pheromone);
					fails++;
				end
				if (time_choice !== e.tc) begin
					$display("%0t: time_choice expected %0d actual %0d", $time, e.tc,
						time_choice);
					fails++;
				end
				if (dest_pheromone !== e.dp) begin
					$display("%0t: dest_pheromone expected %0d actual %0d", $time, e.dp,
						dest_pheromone);
					fails++;
				end
				if (dest_choice !== e.dc) begin
					$display("%0t: dest_choice expected %0d actual %0d", $time, e.dc,
						dest_choice);
					fails++;
				end
			end
		end
	end

	initial cycles = 0;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

endmodule
